[src/stp_pkg.sv]
`default_nettype none

package stp_pkg;

  localparam int BYTE_W   = 8;
  localparam int RADIX_W  = 6;
  localparam int LEN_W    = 7;
  localparam int VALUE_W  = 64;
  localparam int OFFSET_W = 7;
  localparam int STATUS_W = 2;
  localparam int DIGIT_W  = 6;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam int COUNT_LIMIT_DEF = 127;

  localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
  localparam logic [LEN_W-1:0]   LEN_RST   = 7'd21;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd62;
  localparam logic [RADIX_W-1:0] RADIX_DEC     = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_ALNUM   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_MIXED   = 6'd62;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX        = 1'd0,
    CFG_LENGTH_LIMIT = 1'd1
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_BASE = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] value;
  } digit_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] offset;
    status_t             status;
  } result_t;

endpackage

`default_nettype wire

[src/string_to_signed_parser.sv]
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_char_byte (8)
// out      output     out_valid/out_stall out_parsed_value (64 s), out_end_offset (7),
//                                        out_status (2)
// cfg      input      cfg_we             cfg_index (1), cfg_data (7)
//
// one byte per cycle sustained while no stalled result holds a zero byte; a zero byte
// waits in the byte register, and its result is then loaded into the output register
// the rate is set by the combinational multiply-add and range compare on the
// accumulator, which closes its loop every byte
// synchronous active-low reset clears valids and parse state and reloads the register defaults
// a stalled result holds only a zero byte behind it; other bytes keep flowing
`default_nettype none

module string_to_signed_parser #(
  parameter int COUNT_LIMIT = stp_pkg::COUNT_LIMIT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [stp_pkg::BYTE_W-1:0]    in_char_byte,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [stp_pkg::VALUE_W-1:0] out_parsed_value,
  output      logic [stp_pkg::OFFSET_W-1:0]  out_end_offset,
  output      logic [stp_pkg::STATUS_W-1:0]  out_status,
  input  wire logic                          cfg_we,
  input  wire logic [stp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stp_pkg::CFG_W-1:0]     cfg_data
);

  logic [stp_pkg::RADIX_W-1:0] radix_r;
  logic [stp_pkg::LEN_W-1:0]   len_r;

  logic                        byte_vld_r, byte_vld_nxt;
  logic [stp_pkg::BYTE_W-1:0]  byte_r;
  logic                        out_vld_r, out_vld_nxt;
  stp_pkg::result_t            out_res_r;
  stp_pkg::result_t            result;

  logic                        is_end;
  logic                        advance;
  logic                        accept;

  assign is_end  = (byte_r == stp_pkg::CH_NUL);
  assign advance = byte_vld_r && (!is_end || !out_vld_r || !out_stall);
  assign in_stall = byte_vld_r && !advance;
  assign accept  = in_valid && !in_stall;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (accept) begin
      byte_vld_nxt = 1'b1;
    end else if (advance) begin
      byte_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance && is_end) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= stp_pkg::RADIX_RST;
      len_r   <= stp_pkg::LEN_RST;
    end else if (cfg_we) begin
      unique case (stp_pkg::cfg_idx_t'(cfg_index))
        stp_pkg::CFG_RADIX:        radix_r <= cfg_data[stp_pkg::RADIX_W-1:0];
        stp_pkg::CFG_LENGTH_LIMIT: len_r   <= cfg_data[stp_pkg::LEN_W-1:0];
        default:                   radix_r <= radix_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_char_byte;
    end
    if (advance && is_end) begin
      out_res_r <= result;
    end
  end

  stp_parse_core #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance && !is_end),
    .finish       (advance && is_end),
    .char_byte    (byte_r),
    .radix        (radix_r),
    .length_limit (len_r),
    .result       (result)
  );

  assign out_valid        = out_vld_r;
  assign out_parsed_value = out_res_r.value;
  assign out_end_offset   = out_res_r.offset;
  assign out_status       = out_res_r.status;

  a_stall_only_behind_full_out : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_vld_r && out_stall && is_end))
    else $error("input stalled without a blocked result");

  a_err_gives_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == stp_pkg::ST_TOO_LONG ||
                   out_status == stp_pkg::ST_BAD_BASE))
    |-> (out_parsed_value == '0 && out_end_offset == '0))
    else $error("error result carries a value or offset");

  a_ovf_saturates : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == stp_pkg::ST_OVERFLOW)
    |-> ((out_parsed_value == stp_pkg::POS_LIMIT || out_parsed_value == stp_pkg::NEG_LIMIT)
         && out_end_offset == '0))
    else $error("overflow result not saturated");

  a_result_loads_on_end : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_end) |=> out_vld_r)
    else $error("zero byte transfer lost its result");

endmodule

`default_nettype wire

[src/stp_digit_decode.sv]
`default_nettype none

module stp_digit_decode (
  input  wire logic [stp_pkg::BYTE_W-1:0]  char_byte,
  input  wire logic [stp_pkg::RADIX_W-1:0] radix,
  output stp_pkg::digit_t                  digit
);

  logic                       is_num;
  logic                       is_upper;
  logic                       is_lower;
  logic                       has_val;
  logic [stp_pkg::BYTE_W-1:0] val;

  always_comb begin
    is_num   = (char_byte >= stp_pkg::CH_ZERO) && (char_byte <= stp_pkg::CH_NINE);
    is_upper = (char_byte >= stp_pkg::CH_UA) && (char_byte <= stp_pkg::CH_UZ);
    is_lower = (char_byte >= stp_pkg::CH_LA) && (char_byte <= stp_pkg::CH_LZ);
    has_val  = 1'b0;
    val      = '0;
    if (is_num) begin
      has_val = 1'b1;
      val     = char_byte - stp_pkg::CH_ZERO;
    end else if ((radix > stp_pkg::RADIX_DEC) && (is_upper || is_lower)) begin
      if (radix <= stp_pkg::RADIX_ALNUM) begin
        has_val = 1'b1;
        val     = is_upper ? char_byte - stp_pkg::CH_UA + 8'(stp_pkg::RADIX_DEC)
                           : char_byte - stp_pkg::CH_LA + 8'(stp_pkg::RADIX_DEC);
      end else if (radix == stp_pkg::RADIX_MIXED) begin
        has_val = 1'b1;
        val     = is_upper ? char_byte - stp_pkg::CH_UA + 8'(stp_pkg::RADIX_DEC)
                           : char_byte - stp_pkg::CH_LA + 8'(stp_pkg::RADIX_ALNUM);
      end
    end
    digit.value = val[stp_pkg::DIGIT_W-1:0];
    digit.ok    = has_val && (val < 8'(radix));
  end

endmodule

`default_nettype wire

[src/stp_parse_core.sv]
`default_nettype none

module stp_parse_core #(
  parameter int COUNT_LIMIT = stp_pkg::COUNT_LIMIT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        finish,
  input  wire logic [stp_pkg::BYTE_W-1:0]  char_byte,
  input  wire logic [stp_pkg::RADIX_W-1:0] radix,
  input  wire logic [stp_pkg::LEN_W-1:0]   length_limit,
  output stp_pkg::result_t                 result
);

  localparam int CNT_W  = $clog2(COUNT_LIMIT + 1);
  localparam int MAC_W  = stp_pkg::VALUE_W + stp_pkg::RADIX_W + 1;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic                        neg_r, neg_nxt;
  logic [stp_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            stop_r, stop_nxt;
  logic                        ovf_r, ovf_nxt;

  stp_pkg::digit_t             digit;
  logic [MAC_W-1:0]            mac;
  logic [MAC_W-1:0]            lim;
  logic                        is_space;
  logic                        is_sign;
  logic                        take_digit;

  stp_digit_decode u_digit (
    .char_byte (char_byte),
    .radix     (radix),
    .digit     (digit)
  );

  assign mac = MAC_W'(acc_r) * MAC_W'(radix) + MAC_W'(digit.value);
  assign lim = neg_r ? MAC_W'(stp_pkg::NEG_LIMIT) : MAC_W'(stp_pkg::POS_LIMIT);

  assign is_space = (char_byte == stp_pkg::CH_SPACE) ||
                    ((char_byte >= stp_pkg::CH_TAB) && (char_byte <= stp_pkg::CH_CR));
  assign is_sign  = (char_byte == stp_pkg::CH_PLUS) || (char_byte == stp_pkg::CH_MINUS);

  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    stop_nxt   = stop_r;
    ovf_nxt    = ovf_r;
    take_digit = 1'b0;
    if (finish) begin
      phase_nxt = PH_SKIP;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      stop_nxt  = '0;
      ovf_nxt   = 1'b0;
    end else if (step) begin
      if (cnt_r < CNT_W'(COUNT_LIMIT)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      unique case (phase_r)
        PH_SKIP: begin
          if (is_space) begin
            stop_nxt = cnt_nxt;
          end else if (is_sign) begin
            phase_nxt = PH_DIGITS;
            neg_nxt   = (char_byte == stp_pkg::CH_MINUS);
            stop_nxt  = cnt_nxt;
          end else begin
            phase_nxt  = PH_DIGITS;
            take_digit = 1'b1;
          end
        end
        PH_DIGITS: take_digit = 1'b1;
        PH_DONE:   take_digit = 1'b0;
        default:   take_digit = 1'b0;
      endcase
      if (take_digit) begin
        if (!digit.ok) begin
          phase_nxt = PH_DONE;
        end else if (mac > lim) begin
          ovf_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          acc_nxt  = mac[stp_pkg::VALUE_W-1:0];
          stop_nxt = cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
      stop_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      stop_r  <= stop_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // result as seen at the terminating zero byte
  always_comb begin
    result.value  = '0;
    result.offset = '0;
    result.status = stp_pkg::ST_OK;
    priority if (cnt_r > CNT_W'(length_limit)) begin
      result.status = stp_pkg::ST_TOO_LONG;
    end else if ((radix < stp_pkg::RADIX_MIN) || (radix > stp_pkg::RADIX_MAX)) begin
      result.status = stp_pkg::ST_BAD_BASE;
    end else if (ovf_r) begin
      result.value  = neg_r ? stp_pkg::NEG_LIMIT : stp_pkg::POS_LIMIT;
      result.status = stp_pkg::ST_OVERFLOW;
    end else begin
      result.value  = neg_r ? (~acc_r + 1'b1) : acc_r;
      result.offset = stop_r[stp_pkg::OFFSET_W-1:0];
    end
  end

endmodule

`default_nettype wire
